>>> rtl/obbsat_pkg.sv
// ----------------------------------------------------------------------------
// obbsat_pkg
// Shared widths, latencies and types of the oriented box overlap pipeline.
// ----------------------------------------------------------------------------
package obbsat_pkg;

    localparam int IN_W       = 32;              // input word, signed fixed point
    localparam int NUM_VEC    = 6;               // vectors in one input item
    localparam int IN_DATA_W  = 2 * NUM_VEC * IN_W;
    localparam int OUT_DATA_W = 72;              // 65 result bits padded to bytes
    localparam int AXIS_FRAC  = 28;              // fraction bits of a unit axis
    localparam int AXIS_W     = AXIS_FRAC + 2;   // signed axis component
    localparam int OV_W       = 66;              // signed overlap
    localparam int NUM_AXES   = 4;

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 30;
    localparam int NORM_STEPS = 5;
    localparam int UNIT_LAT   = 2 + NORM_STEPS + SQRT_STEPS + 1 + DIV_STEPS + 1;
    localparam int OVL_LAT    = 5;
    localparam int PUSH_LAT   = 6;
    localparam int PIPE_LAT   = UNIT_LAT + OVL_LAT + PUSH_LAT;

    typedef logic signed [IN_W-1:0]   t_word;
    typedef logic signed [AXIS_W-1:0] t_axc;

    typedef struct packed {
        t_word x;
        t_word y;
    } t_vec;

    // unit vector of one half-extent, nz low for a zero vector
    typedef struct packed {
        logic nz;
        t_axc ux;
        t_axc uy;
    } t_unit;

    // overlap result of one axis
    typedef struct packed {
        logic                   vld;
        logic                   dneg;
        logic signed [OV_W-1:0] ov;
        t_axc                   ax;
        t_axc                   ay;
    } t_ovl;

endpackage

>>> rtl/obbsat_unit.sv
// ----------------------------------------------------------------------------
// obbsat_unit
// Unit vector of a half-extent: squares, even normalize, digit-by-digit
// square root and restoring division, one step per pipeline stage.
// ----------------------------------------------------------------------------
module obbsat_unit
    import obbsat_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_en,
    input  t_word i_ex,
    input  t_word i_ey,
    output t_unit o_unit
);

    localparam int MAG_W = IN_W;
    localparam int SQ_W  = 2 * IN_W;
    localparam int DEN_W = SQRT_STEPS;
    localparam int REM_W = 62;
    localparam int Q_W   = DIV_STEPS;
    localparam logic [Q_W-1:0] Q_ONE = Q_W'(1) << AXIS_FRAC;

    typedef struct packed {
        logic             nz;
        logic             sx;
        logic             sy;
        logic [MAG_W-1:0] mx;
        logic [MAG_W-1:0] my;
    } t_side;

    logic [MAG_W-1:0] w_mx, w_my;
    logic [SQ_W-1:0]  w_sqx, w_sqy;
    logic [SQ_W-1:0]  r1_sqx, r1_sqy;
    t_side            r1_sd;

    assign w_mx  = i_ex[IN_W-1] ? MAG_W'(~i_ex) + 1'b1 : MAG_W'(i_ex);
    assign w_my  = i_ey[IN_W-1] ? MAG_W'(~i_ey) + 1'b1 : MAG_W'(i_ey);
    assign w_sqx = SQ_W'(w_mx) * SQ_W'(w_mx);
    assign w_sqy = SQ_W'(w_my) * SQ_W'(w_my);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sqx   <= w_sqx;
            r1_sqy   <= w_sqy;
            r1_sd.nz <= ((w_mx | w_my) != '0);
            r1_sd.sx <= i_ex[IN_W-1];
            r1_sd.sy <= i_ey[IN_W-1];
            r1_sd.mx <= w_mx;
            r1_sd.my <= w_my;
        end
    end

    // normalize by an even shift until one of the top two bits is set
    logic [SQ_W-1:0] r_ns  [0:NORM_STEPS];
    t_side           r_nsd [0:NORM_STEPS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ns[0]  <= r1_sqx + r1_sqy;
            r_nsd[0] <= r1_sd;
        end
    end

    for (genvar t = 0; t < NORM_STEPS; t++) begin : g_norm
        localparam int SH = 32 >> t;
        logic  w_top0;
        t_side w_sd;

        assign w_top0 = (r_ns[t][SQ_W-1 -: SH] == '0);

        always_comb begin
            w_sd = r_nsd[t];
            if (w_top0) begin
                w_sd.mx = r_nsd[t].mx << (SH / 2);
                w_sd.my = r_nsd[t].my << (SH / 2);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ns[t+1]  <= w_top0 ? (r_ns[t] << SH) : r_ns[t];
                r_nsd[t+1] <= w_sd;
            end
        end
    end

    // square root, one result bit per stage
    logic [SQ_W-1:0] r_qv  [0:SQRT_STEPS-1];
    logic [SQ_W-1:0] r_qr  [0:SQRT_STEPS-1];
    t_side           r_qsd [0:SQRT_STEPS-1];

    for (genvar t = 0; t < SQRT_STEPS; t++) begin : g_sqrt
        localparam logic [SQ_W-1:0] STEP_BIT = SQ_W'(1) << (62 - 2 * t);
        logic [SQ_W-1:0] w_v, w_r, w_trial;
        t_side           w_sd;
        logic            w_ge;

        if (t == 0) begin : g_in0
            assign w_v  = r_ns[NORM_STEPS];
            assign w_r  = '0;
            assign w_sd = r_nsd[NORM_STEPS];
        end else begin : g_inn
            assign w_v  = r_qv[t-1];
            assign w_r  = r_qr[t-1];
            assign w_sd = r_qsd[t-1];
        end

        assign w_trial = w_r + STEP_BIT;
        assign w_ge    = (w_v >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_qv[t]  <= w_ge ? (w_v - w_trial) : w_v;
                r_qr[t]  <= (w_r >> 1) + (w_ge ? STEP_BIT : '0);
                r_qsd[t] <= w_sd;
            end
        end
    end

    // rounded division of the shifted magnitude by the length
    logic [REM_W-1:0] r_dnx  [0:DIV_STEPS];
    logic [REM_W-1:0] r_dny  [0:DIV_STEPS];
    logic [Q_W-1:0]   r_dqx  [0:DIV_STEPS];
    logic [Q_W-1:0]   r_dqy  [0:DIV_STEPS];
    logic [DEN_W-1:0] r_dlen [0:DIV_STEPS];
    t_side            r_dsd  [0:DIV_STEPS];
    logic [DEN_W-1:0] w_len;

    assign w_len = r_qr[SQRT_STEPS-1][DEN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dnx[0]  <= REM_W'({r_qsd[SQRT_STEPS-1].mx, {AXIS_FRAC{1'b0}}})
                         + REM_W'(w_len >> 1);
            r_dny[0]  <= REM_W'({r_qsd[SQRT_STEPS-1].my, {AXIS_FRAC{1'b0}}})
                         + REM_W'(w_len >> 1);
            r_dqx[0]  <= '0;
            r_dqy[0]  <= '0;
            r_dlen[0] <= w_len;
            r_dsd[0]  <= r_qsd[SQRT_STEPS-1];
        end
    end

    for (genvar t = 0; t < DIV_STEPS; t++) begin : g_div
        localparam int J = DIV_STEPS - 1 - t;
        logic [REM_W-1:0] w_dv;
        logic             w_gex, w_gey;

        assign w_dv  = REM_W'(r_dlen[t]) << J;
        assign w_gex = (r_dnx[t] >= w_dv);
        assign w_gey = (r_dny[t] >= w_dv);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dnx[t+1]  <= w_gex ? (r_dnx[t] - w_dv) : r_dnx[t];
                r_dny[t+1]  <= w_gey ? (r_dny[t] - w_dv) : r_dny[t];
                r_dqx[t+1]  <= {r_dqx[t][Q_W-2:0], w_gex};
                r_dqy[t+1]  <= {r_dqy[t][Q_W-2:0], w_gey};
                r_dlen[t+1] <= r_dlen[t];
                r_dsd[t+1]  <= r_dsd[t];
            end
        end
    end

    function automatic t_axc unit_comp(logic [Q_W-1:0] q, logic s, logic nz);
        logic [Q_W-1:0] c;
        c = (q > Q_ONE) ? Q_ONE : q;
        if (!nz) begin
            return '0;
        end
        return s ? t_axc'(AXIS_W'(0) - AXIS_W'(c)) : t_axc'(c);
    endfunction

    t_unit r_unit;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_unit.nz <= r_dsd[DIV_STEPS].nz;
            r_unit.ux <= unit_comp(r_dqx[DIV_STEPS], r_dsd[DIV_STEPS].sx,
                                   r_dsd[DIV_STEPS].nz);
            r_unit.uy <= unit_comp(r_dqy[DIV_STEPS], r_dsd[DIV_STEPS].sy,
                                   r_dsd[DIV_STEPS].nz);
        end
    end

    assign o_unit = r_unit;

endmodule

>>> rtl/obbsat_ovl.sv
// ----------------------------------------------------------------------------
// obbsat_ovl
// Projects both boxes on one axis and forms the overlap
// radius_a + radius_b - |centre distance|.
// ----------------------------------------------------------------------------
module obbsat_ovl
    import obbsat_pkg::*;
(
    input  logic i_clk,
    input  logic i_en,
    input  logic i_axis_ok,
    input  t_axc i_ax,
    input  t_axc i_ay,
    input  t_vec i_vec [0:NUM_VEC-1],   // a centre, b centre, a x, a y, b x, b y
    output t_ovl o_ovl
);

    localparam int PRD_W = AXIS_W + IN_W;
    localparam int DOT_W = PRD_W + 1;
    localparam int D_W   = DOT_W + 1;
    localparam int R_W   = D_W + 1;

    typedef struct packed {
        logic vld;
        t_axc ax;
        t_axc ay;
    } t_axis;

    function automatic logic [DOT_W-1:0] dot_mag(logic signed [DOT_W-1:0] d);
        return d[DOT_W-1] ? DOT_W'(-d) : DOT_W'(d);
    endfunction

    logic signed [PRD_W-1:0] r1_p [0:2*NUM_VEC-1];
    logic signed [DOT_W-1:0] r2_dot [0:NUM_VEC-1];
    logic signed [D_W-1:0]   r3_d;
    logic [D_W-1:0]          r3_ra, r3_rb;
    logic [R_W-1:0]          r4_r;
    logic [D_W-1:0]          r4_ad;
    logic                    r4_dneg;
    t_axis                   r1_a, r2_a, r3_a, r4_a;
    t_ovl                    r_ovl;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NUM_VEC; i++) begin
                r1_p[2*i]   <= PRD_W'(i_ax) * PRD_W'(i_vec[i].x);
                r1_p[2*i+1] <= PRD_W'(i_ay) * PRD_W'(i_vec[i].y);
            end
            r1_a.vld <= i_axis_ok;
            r1_a.ax  <= i_ax;
            r1_a.ay  <= i_ay;

            for (int i = 0; i < NUM_VEC; i++) begin
                r2_dot[i] <= DOT_W'(r1_p[2*i]) + DOT_W'(r1_p[2*i+1]);
            end
            r2_a <= r1_a;

            // centre distance and the two box radii on this axis
            r3_d  <= D_W'(r2_dot[0]) - D_W'(r2_dot[1]);
            r3_ra <= D_W'(dot_mag(r2_dot[2])) + D_W'(dot_mag(r2_dot[3]));
            r3_rb <= D_W'(dot_mag(r2_dot[4])) + D_W'(dot_mag(r2_dot[5]));
            r3_a  <= r2_a;

            r4_r    <= R_W'(r3_ra) + R_W'(r3_rb);
            r4_ad   <= r3_d[D_W-1] ? D_W'(-r3_d) : D_W'(r3_d);
            r4_dneg <= r3_d[D_W-1];
            r4_a    <= r3_a;

            r_ovl.vld  <= r4_a.vld;
            r_ovl.dneg <= r4_dneg;
            r_ovl.ov   <= signed'(OV_W'(r4_r)) - signed'(OV_W'(r4_ad));
            r_ovl.ax   <= r4_a.ax;
            r_ovl.ay   <= r4_a.ay;
        end
    end

    assign o_ovl = r_ovl;

endmodule

>>> rtl/obbsat_push.sv
// ----------------------------------------------------------------------------
// obbsat_push
// Picks the axis of least overlap, rounds the overlap and scales the axis
// into the saturated push vector.
// ----------------------------------------------------------------------------
module obbsat_push
    import obbsat_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_en,
    input  t_ovl  i_ovl [0:NUM_AXES-1],
    output logic  o_collides,
    output t_word o_push_x,
    output t_word o_push_y
);

    localparam int OVR_W = 36;
    localparam int HALF  = OVR_W / 2;
    localparam int MAG_W = AXIS_W - 1;
    localparam int PP_W  = HALF + MAG_W;
    localparam int SUM_W = 66;
    localparam int RS_W  = SUM_W - AXIS_FRAC;

    function automatic logic later_wins(t_ovl a, t_ovl b);
        return b.vld && (!a.vld || (b.ov < a.ov));
    endfunction

    function automatic t_word sat_word(logic [RS_W-1:0] r, logic neg);
        if (!neg) begin
            return (r > RS_W'({1'b0, {(IN_W-1){1'b1}}})) ?
                   t_word'({1'b0, {(IN_W-1){1'b1}}}) : t_word'(r[IN_W-1:0]);
        end
        return (r >= (RS_W'(1) << (IN_W - 1))) ?
               t_word'({1'b1, {(IN_W-1){1'b0}}}) :
               t_word'(IN_W'(0) - r[IN_W-1:0]);
    endfunction

    logic w_fail, w_any;

    always_comb begin
        w_fail = 1'b0;
        w_any  = 1'b0;
        for (int i = 0; i < NUM_AXES; i++) begin
            w_fail = w_fail | (i_ovl[i].vld &&
                               (i_ovl[i].ov[OV_W-1] || (i_ovl[i].ov == '0)));
            w_any  = w_any | i_ovl[i].vld;
        end
    end

    t_ovl                r1_w0, r1_w1, r2_best;
    logic                r1_col, r2_col, r3_col, r4_col, r5_col;
    logic [OVR_W-1:0]    r3_ovr;
    logic [MAG_W-1:0]    r3_mx, r3_my;
    logic                r3_nx, r3_ny, r4_nx, r4_ny, r5_nx, r5_ny;
    logic [PP_W-1:0]     r4_hx, r4_lx, r4_hy, r4_ly;
    logic [RS_W-1:0]     r5_rx, r5_ry;
    logic [OV_W-1:0]     w_rnd;
    logic [SUM_W-1:0]    w_sx, w_sy;
    logic                r_col;
    t_word               r_px, r_py;

    assign w_rnd = unsigned'(r2_best.ov) + (OV_W'(1) << (AXIS_FRAC - 1));
    assign w_sx  = (SUM_W'(r4_hx) << HALF) + SUM_W'(r4_lx)
                   + (SUM_W'(1) << (AXIS_FRAC - 1));
    assign w_sy  = (SUM_W'(r4_hy) << HALF) + SUM_W'(r4_ly)
                   + (SUM_W'(1) << (AXIS_FRAC - 1));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // earlier axis keeps ties
            r1_w0  <= later_wins(i_ovl[0], i_ovl[1]) ? i_ovl[1] : i_ovl[0];
            r1_w1  <= later_wins(i_ovl[2], i_ovl[3]) ? i_ovl[3] : i_ovl[2];
            r1_col <= w_any && !w_fail;

            r2_best <= later_wins(r1_w0, r1_w1) ? r1_w1 : r1_w0;
            r2_col  <= r1_col;

            r3_ovr <= w_rnd[AXIS_FRAC +: OVR_W];
            r3_mx  <= r2_best.ax[AXIS_W-1] ? MAG_W'(-r2_best.ax) : MAG_W'(r2_best.ax);
            r3_my  <= r2_best.ay[AXIS_W-1] ? MAG_W'(-r2_best.ay) : MAG_W'(r2_best.ay);
            r3_nx  <= r2_best.ax[AXIS_W-1] ^ r2_best.dneg;
            r3_ny  <= r2_best.ay[AXIS_W-1] ^ r2_best.dneg;
            r3_col <= r2_col;

            // overlap split in halves to keep each multiplier narrow
            r4_hx  <= PP_W'(r3_ovr[OVR_W-1:HALF]) * PP_W'(r3_mx);
            r4_lx  <= PP_W'(r3_ovr[HALF-1:0]) * PP_W'(r3_mx);
            r4_hy  <= PP_W'(r3_ovr[OVR_W-1:HALF]) * PP_W'(r3_my);
            r4_ly  <= PP_W'(r3_ovr[HALF-1:0]) * PP_W'(r3_my);
            r4_nx  <= r3_nx;
            r4_ny  <= r3_ny;
            r4_col <= r3_col;

            r5_rx  <= w_sx[SUM_W-1:AXIS_FRAC];
            r5_ry  <= w_sy[SUM_W-1:AXIS_FRAC];
            r5_nx  <= r4_nx;
            r5_ny  <= r4_ny;
            r5_col <= r4_col;

            r_col <= r5_col;
            r_px  <= r5_col ? sat_word(r5_rx, r5_nx) : '0;
            r_py  <= r5_col ? sat_word(r5_ry, r5_ny) : '0;
        end
    end

    assign o_collides = r_col;
    assign o_push_x   = r_px;
    assign o_push_y   = r_py;

endmodule

>>> rtl/obb_obb_sat_penetration.sv
// ----------------------------------------------------------------------------
// obb_obb_sat_penetration
// Separating axis test of two oriented boxes with minimum translation vector.
// ----------------------------------------------------------------------------
// an accepted item passes the unit axis, overlap and push pipelines, then the output register to o_m_tvalid
// throughput: one item per clock while not stalled; 71 of the stages are the unit axis
//   pipelines, 62 of them square-root and divider steps, one result bit each
// stalls hold the pipeline only when its last stage is full and the output
//   register is not taken; reset clears all valid bits, no clearing pass
module obb_obb_sat_penetration
    import obbsat_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // a_center_x, a_center_y, a_xext_x, a_xext_y, a_yext_x, a_yext_y,
    // b_center_x, b_center_y, b_xext_x, b_xext_y, b_yext_x, b_yext_y
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // collides, push_x, push_y, zero padding
    output logic [OUT_DATA_W-1:0] o_m_tdata
);

    logic                 w_en;
    logic [PIPE_LAT-1:0]  r_vld;
    logic                 r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [IN_DATA_W-1:0] r_dly [0:UNIT_LAT-1];

    assign w_en       = !r_vld[PIPE_LAT-1] || !r_out_valid || i_m_tready;
    assign o_s_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_en) begin
                r_vld <= {r_vld[PIPE_LAT-2:0], i_s_tvalid};
            end
            if (!r_out_valid || i_m_tready) begin
                r_out_valid <= r_vld[PIPE_LAT-1];
            end
        end
    end

    // box data waits alongside the unit axis pipelines
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dly[0] <= i_s_tdata;
            for (int t = 1; t < UNIT_LAT; t++) begin
                r_dly[t] <= r_dly[t-1];
            end
        end
    end

    t_vec  w_ext [0:NUM_AXES-1];
    t_vec  w_dl [0:NUM_VEC-1];
    t_vec  w_ov_vec [0:NUM_VEC-1];
    t_unit w_unit [0:NUM_AXES-1];
    t_ovl  w_ovl [0:NUM_AXES-1];

    for (genvar k = 0; k < NUM_VEC; k++) begin : g_unpack
        assign w_dl[k].x = t_word'(r_dly[UNIT_LAT-1][2*k*IN_W +: IN_W]);
        assign w_dl[k].y = t_word'(r_dly[UNIT_LAT-1][(2*k+1)*IN_W +: IN_W]);
    end

    // extents only: a x, a y, b x, b y
    for (genvar k = 0; k < NUM_AXES; k++) begin : g_ext
        localparam int V = k + 1 + (k >> 1);
        assign w_ext[k].x = t_word'(i_s_tdata[2*V*IN_W +: IN_W]);
        assign w_ext[k].y = t_word'(i_s_tdata[(2*V+1)*IN_W +: IN_W]);
    end

    // order seen by the projection: a center, b center, a x, a y, b x, b y
    assign w_ov_vec[0] = w_dl[0];
    assign w_ov_vec[1] = w_dl[3];
    assign w_ov_vec[2] = w_dl[1];
    assign w_ov_vec[3] = w_dl[2];
    assign w_ov_vec[4] = w_dl[4];
    assign w_ov_vec[5] = w_dl[5];

    // units: a x, a y, b x, b y extents
    for (genvar k = 0; k < NUM_AXES; k++) begin : g_unit
        obbsat_unit u_unit (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_ex   (w_ext[k].x),
            .i_ey   (w_ext[k].y),
            .o_unit (w_unit[k])
        );
    end

    // axis i is the normal of the side along the other extent of its box;
    // the opposite sides give the same overlap and lose every tie
    for (genvar i = 0; i < NUM_AXES; i++) begin : g_axis
        obbsat_ovl u_ovl (
            .i_clk     (i_clk),
            .i_en      (w_en),
            .i_axis_ok (w_unit[i ^ 1].nz),
            .i_ax      (w_unit[i ^ 1].uy),
            .i_ay      (t_axc'(-w_unit[i ^ 1].ux)),
            .i_vec     (w_ov_vec),
            .o_ovl     (w_ovl[i])
        );
    end

    logic  w_col;
    t_word w_push_x, w_push_y;

    obbsat_push u_push (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_ovl      (w_ovl),
        .o_collides (w_col),
        .o_push_x   (w_push_x),
        .o_push_y   (w_push_y)
    );

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_m_tready) begin
            r_out_data <= {{(OUT_DATA_W - 2*IN_W - 1){1'b0}}, w_push_y, w_push_x, w_col};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    a_no_push_without_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[0] |-> o_m_tdata[2*IN_W:1] == '0)
        else $error("push vector nonzero without collision");

    a_stall_holds_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline valid bits moved during a stall");

    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[PIPE_LAT-1] && r_out_valid && !i_m_tready |-> !o_s_tready)
        else $error("item taken while the full pipeline is stalled");

    a_result_from_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_vld[PIPE_LAT-1]))
        else $error("result appeared without an item in the last stage");

endmodule
